// File: sv/ksdm_pkg.sv
// Shared types and constants for the knob smoother, deadband and range mapper.
package ksdm_pkg;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_COEFF = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAX    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CURVE_EXP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG2_RATIO   = 3'd5;

  localparam logic [16:0] POS_FULL        = 17'd65536;
  localparam logic [16:0] DEADBAND_RESET  = 17'd328;
  localparam logic [31:0] RANGE_MAX_RESET = 32'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_CHECK,
    ST_LIN_MUL,
    ST_LIN_SUM,
    ST_EXP_MUL,
    ST_EXP_ADDR,
    ST_EXP_LO,
    ST_EXP_HI,
    ST_EXP_INT,
    ST_EXP_V,
    ST_EXP_SCALE,
    ST_EXP_SHIFT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILT,
    OP_CHECK,
    OP_LIN_MUL,
    OP_LIN_SUM,
    OP_EXP_MUL,
    OP_EXP_ADDR,
    OP_EXP_LO,
    OP_EXP_HI,
    OP_EXP_INT,
    OP_EXP_V,
    OP_EXP_SCALE,
    OP_EXP_SHIFT,
    OP_DELIVER
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic need_map;
    logic use_exp;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [15:0]        smooth_coeff;
    logic [16:0]        deadband;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic               curve_exp;
    logic [20:0]        log2_ratio;
  } cfg_t;

endpackage

// File: sv/ksdm_exp_rom.sv
// Table of 2^f in Q30 for the exponential curve, built at elaboration, registered read.
module ksdm_exp_rom #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic [$clog2(DEPTH+1)-1:0]     addr,
  output logic [31:0]                    data
);

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] pow2_q30(input logic [15:0] f);
    logic [63:0] r;
    logic [63:0] root;
    r = 64'd1 << 30;
    root = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      root = isqrt64(root << 30);
      if (f[16-i]) begin
        r = (r * root + (64'd1 << 29)) >> 30;
      end
    end
    return r[31:0];
  endfunction

  logic [31:0] tab [0:DEPTH];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam int unsigned FRAC = (k * 65536) / DEPTH;
    localparam logic [31:0] VAL = (k == DEPTH) ? 32'h8000_0000 : pow2_q30(FRAC[15:0]);
    assign tab[k] = VAL;
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

// File: sv/ksdm_ctrl.sv
// Sequencing state machine for the smoother and mapper datapath.
module ksdm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ksdm_pkg::stat_t status,
  output ksdm_pkg::cmd_t  cmd
);

  ksdm_pkg::state_t state;
  ksdm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksdm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.op      = ksdm_pkg::OP_NONE;
    case (state)
      ksdm_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ksdm_pkg::ST_FILT;
        end
      end
      ksdm_pkg::ST_FILT: begin
        cmd.op     = ksdm_pkg::OP_FILT;
        state_next = ksdm_pkg::ST_CHECK;
      end
      ksdm_pkg::ST_CHECK: begin
        cmd.op = ksdm_pkg::OP_CHECK;
        if (!status.need_map) begin
          state_next = ksdm_pkg::ST_DONE;
        end else if (status.use_exp) begin
          state_next = ksdm_pkg::ST_EXP_MUL;
        end else begin
          state_next = ksdm_pkg::ST_LIN_MUL;
        end
      end
      ksdm_pkg::ST_LIN_MUL: begin
        cmd.op     = ksdm_pkg::OP_LIN_MUL;
        state_next = ksdm_pkg::ST_LIN_SUM;
      end
      ksdm_pkg::ST_LIN_SUM: begin
        cmd.op     = ksdm_pkg::OP_LIN_SUM;
        state_next = ksdm_pkg::ST_DONE;
      end
      ksdm_pkg::ST_EXP_MUL: begin
        cmd.op     = ksdm_pkg::OP_EXP_MUL;
        state_next = ksdm_pkg::ST_EXP_ADDR;
      end
      ksdm_pkg::ST_EXP_ADDR: begin
        cmd.op     = ksdm_pkg::OP_EXP_ADDR;
        state_next = ksdm_pkg::ST_EXP_LO;
      end
      ksdm_pkg::ST_EXP_LO: begin
        cmd.op     = ksdm_pkg::OP_EXP_LO;
        state_next = ksdm_pkg::ST_EXP_HI;
      end
      ksdm_pkg::ST_EXP_HI: begin
        cmd.op     = ksdm_pkg::OP_EXP_HI;
        state_next = ksdm_pkg::ST_EXP_INT;
      end
      ksdm_pkg::ST_EXP_INT: begin
        cmd.op     = ksdm_pkg::OP_EXP_INT;
        state_next = ksdm_pkg::ST_EXP_V;
      end
      ksdm_pkg::ST_EXP_V: begin
        cmd.op     = ksdm_pkg::OP_EXP_V;
        state_next = ksdm_pkg::ST_EXP_SCALE;
      end
      ksdm_pkg::ST_EXP_SCALE: begin
        cmd.op     = ksdm_pkg::OP_EXP_SCALE;
        state_next = ksdm_pkg::ST_EXP_SHIFT;
      end
      ksdm_pkg::ST_EXP_SHIFT: begin
        cmd.op     = ksdm_pkg::OP_EXP_SHIFT;
        state_next = ksdm_pkg::ST_DONE;
      end
      ksdm_pkg::ST_DONE: begin
        cmd.op = ksdm_pkg::OP_DELIVER;
        if (status.out_free) begin
          state_next = ksdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ksdm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ksdm_dp.sv
// Datapath: clamp, lowpass, deadband test, shared multiplier, range mapping, output register.
module ksdm_dp #(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ksdm_pkg::cmd_t      cmd,
  input  ksdm_pkg::cfg_t      cfg,
  input  logic                mode,
  input  logic signed [17:0]  position,
  output ksdm_pkg::stat_t     status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                moved,
  output logic [16:0]         reported_position,
  output logic signed [31:0]  scaled_value
);

  localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW = 16 + AW;

  function automatic logic signed [49:0] rdiv16(input logic signed [65:0] num);
    logic [65:0] mag;
    logic [65:0] sum;
    logic [49:0] q;
    mag = num[65] ? 66'(-num) : 66'(num);
    sum = mag + 66'd32768;
    q = sum[65:16];
    return num[65] ? -$signed(q) : $signed(q);
  endfunction

  // item and filter state
  logic               mode_q;
  logic [16:0]        x;
  logic               started;
  logic [16:0]        smoothed;
  logic [16:0]        last_rep;
  logic signed [31:0] mapped;
  logic [16:0]        t;
  logic               moved_q;

  // mapping work registers
  logic signed [65:0] prod;
  logic [4:0]         ip;
  logic [AW-1:0]      idx;
  logic [15:0]        rem;
  logic [31:0]        lo;
  logic [31:0]        v;

  logic [AW-1:0]      rom_addr;
  logic [31:0]        rom_data;

  logic [16:0]        x_in;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [17:0] sdiff;
  logic signed [32:0] span;
  logic signed [49:0] q_round;
  logic [18:0]        sm_sum;
  logic [16:0]        sm_new;
  logic [16:0]        gap;
  logic               hit;
  logic signed [35:0] lin_sum;
  logic signed [31:0] lin_val;
  logic [37:0]        e_full;
  logic [20:0]        e_val;
  logic [PW-1:0]      pos;
  logic [47:0]        v_full;
  logic [63:0]        p_u;
  logic [4:0]         sh;
  logic [4:0]         sh_m1;
  logic [63:0]        rnd;
  logic [63:0]        shifted;
  logic [31:0]        exp_val;
  logic               deliver;

  always_comb begin
    if (position < 18'sd0) begin
      x_in = 17'd0;
    end else if (position > $signed({1'b0, ksdm_pkg::POS_FULL})) begin
      x_in = ksdm_pkg::POS_FULL;
    end else begin
      x_in = position[16:0];
    end
  end

  assign sdiff   = $signed({1'b0, smoothed}) - $signed({1'b0, x});
  assign span    = $signed({cfg.range_max[31], cfg.range_max})
                 - $signed({cfg.range_min[31], cfg.range_min});
  assign q_round = rdiv16(prod);

  // lowpass update and deadband distance
  assign sm_sum = {2'b00, x} + q_round[18:0];
  assign sm_new = sm_sum[16:0];
  assign gap    = (sm_new >= last_rep) ? (sm_new - last_rep) : (last_rep - sm_new);
  assign hit    = gap >= cfg.deadband;

  // linear map with saturation
  assign lin_sum = $signed({{4{cfg.range_min[31]}}, cfg.range_min}) + q_round[35:0];
  always_comb begin
    if (lin_sum > 36'sd2147483647) begin
      lin_val = 32'sh7FFF_FFFF;
    end else if (lin_sum < -36'sd2147483648) begin
      lin_val = 32'sh8000_0000;
    end else begin
      lin_val = lin_sum[31:0];
    end
  end

  // exponent split into table index and remainder
  assign e_full = prod[37:0] + 38'd32768;
  assign e_val  = e_full[36:16];
  assign pos    = PW'(e_val[15:0]) * PW'(EXP_TABLE_DEPTH);

  assign v_full = prod[47:0] + 48'd32768;

  // final scale by 2^ip with rounding and saturation
  assign p_u     = prod[63:0];
  assign sh      = 5'd30 - ip;
  assign sh_m1   = sh - 5'd1;
  assign rnd     = (ip >= 5'd30) ? 64'd0 : (64'd1 << sh_m1);
  assign shifted = (p_u + rnd) >> sh;
  always_comb begin
    if (ip > 5'd30 || shifted > 64'd2147483647) begin
      exp_val = 32'h7FFF_FFFF;
    end else begin
      exp_val = shifted[31:0];
    end
  end

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (cmd.op)
      ksdm_pkg::OP_FILT: begin
        mul_a = {{15{sdiff[17]}}, sdiff};
        mul_b = {17'd0, cfg.smooth_coeff};
      end
      ksdm_pkg::OP_LIN_MUL: begin
        mul_a = {16'd0, t};
        mul_b = span;
      end
      ksdm_pkg::OP_EXP_MUL: begin
        mul_a = {16'd0, t};
        mul_b = {12'd0, cfg.log2_ratio};
      end
      ksdm_pkg::OP_EXP_INT: begin
        mul_a = {1'b0, rom_data - lo};
        mul_b = {17'd0, rem};
      end
      ksdm_pkg::OP_EXP_SCALE: begin
        mul_a = {1'b0, cfg.range_min};
        mul_b = {1'b0, v};
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign rom_addr = (cmd.op == ksdm_pkg::OP_EXP_LO) ? idx : idx + AW'(1);

  ksdm_exp_rom #(
    .DEPTH(EXP_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      x      <= x_in;
    end
    case (cmd.op)
      ksdm_pkg::OP_FILT,
      ksdm_pkg::OP_LIN_MUL,
      ksdm_pkg::OP_EXP_MUL,
      ksdm_pkg::OP_EXP_INT,
      ksdm_pkg::OP_EXP_SCALE: begin
        prod <= mul_a * mul_b;
      end
      ksdm_pkg::OP_EXP_ADDR: begin
        ip  <= e_val[20:16];
        idx <= pos[PW-1:16];
        rem <= pos[15:0];
      end
      ksdm_pkg::OP_EXP_HI: begin
        lo <= rom_data;
      end
      ksdm_pkg::OP_EXP_V: begin
        v <= lo + v_full[47:16];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      smoothed <= 17'd0;
      last_rep <= 17'd0;
      mapped   <= 32'sd0;
    end else begin
      case (cmd.op)
        ksdm_pkg::OP_CHECK: begin
          if (mode_q) begin
            last_rep <= x;
            t        <= x;
            moved_q  <= 1'b0;
          end else if (!started) begin
            started  <= 1'b1;
            smoothed <= x;
            last_rep <= x;
            t        <= x;
            moved_q  <= 1'b1;
          end else begin
            smoothed <= sm_new;
            moved_q  <= hit;
            if (hit) begin
              last_rep <= sm_new;
              t        <= sm_new;
            end
          end
        end
        ksdm_pkg::OP_LIN_SUM: begin
          mapped <= lin_val;
        end
        ksdm_pkg::OP_EXP_SHIFT: begin
          mapped <= $signed(exp_val);
        end
        default: begin
        end
      endcase
    end
  end

  assign status.need_map = mode_q || !started || hit;
  assign status.use_exp  = cfg.curve_exp && (cfg.range_min > 32'sd0);
  assign status.out_free = !out_valid || out_ready;

  assign deliver = (cmd.op == ksdm_pkg::OP_DELIVER) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      moved             <= moved_q;
      reported_position <= last_rep;
      scaled_value      <= mapped;
    end
  end

endmodule

// File: sv/knob_smoother_deadband_mapper_top.sv
// Top level: configuration registers, controller and datapath.
// Input channel (in_valid/in_ready) takes one item: mode and a signed Q16 position.
// mode 0 is a raw knob sample, smoothed by a one-pole lowpass; a result reports a
// new position only when it moves at least the deadband. mode 1 sets the reported
// position directly from the display. Every item gives exactly one result item.
// Output channel (out_valid/out_ready) carries moved, reported_position (Q16) and
// scaled_value (signed Q16.16, linear or exponential curve).
// Configuration channel (cfg_valid/cfg_ready) writes register cfg_index with
// cfg_data; write only while no item is in flight. Unknown indexes are ignored.
// From accept to out_valid an item passes the filter and check steps, then the linear
// or exponential map steps when it is remapped, then the deliver step. One item is in
// work at a time; the length of its sequence is set by the single shared
// multiplier and the two registered reads of the exponential table.
// A finished result waits in the output register while the next item is accepted;
// the block only holds in its final step if that register is still full.
// Synchronous reset clears the filter state, the reported position and the
// mapped value, and restores register defaults; no item is taken during reset.
module knob_smoother_deadband_mapper_top #(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic signed [17:0]                 position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               moved,
  output logic [16:0]                        reported_position,
  output logic signed [31:0]                 scaled_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ksdm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);

  ksdm_pkg::cfg_t  cfg;
  ksdm_pkg::cmd_t  cmd;
  ksdm_pkg::stat_t status;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_coeff <= 16'd0;
      cfg.deadband     <= ksdm_pkg::DEADBAND_RESET;
      cfg.range_min    <= 32'sd0;
      cfg.range_max    <= ksdm_pkg::RANGE_MAX_RESET;
      cfg.curve_exp    <= 1'b0;
      cfg.log2_ratio   <= 21'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksdm_pkg::REG_SMOOTH_COEFF: cfg.smooth_coeff <= cfg_data[15:0];
        ksdm_pkg::REG_DEADBAND:     cfg.deadband     <= cfg_data[16:0];
        ksdm_pkg::REG_RANGE_MIN:    cfg.range_min    <= cfg_data;
        ksdm_pkg::REG_RANGE_MAX:    cfg.range_max    <= cfg_data;
        ksdm_pkg::REG_CURVE_EXP:    cfg.curve_exp    <= cfg_data[0];
        ksdm_pkg::REG_LOG2_RATIO:   cfg.log2_ratio   <= cfg_data[20:0];
        default: begin
        end
      endcase
    end
  end

  ksdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ksdm_dp #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .mode              (mode),
    .position          (position),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .moved             (moved),
    .reported_position (reported_position),
    .scaled_value      (scaled_value)
  );

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  a_position_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reported_position <= ksdm_pkg::POS_FULL)
    else $error("reported position beyond full scale");

endmodule
